[rtl/ssba_pkg.sv]
package ssba_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int SLOT_W     = 12;
  localparam int HINT_W     = 13;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int WORDS      = SLOT_COUNT / WORD_W;
  localparam int ADDR_W     = $clog2(WORDS);
  localparam int LANES      = WORD_W / 8;
  localparam int LANE_W     = $clog2(LANES);

  localparam logic [1:0] OP_ALLOC         = 2'd0;
  localparam logic [1:0] OP_REL_CHECKED   = 2'd1;
  localparam logic [1:0] OP_REL_UNCHECKED = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_FULL        = 2'd1;
  localparam logic [1:0] ST_BAD_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SLOT_W-1:0] slot;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] granted_slot;
  } out_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane_idx;
    logic [2:0]        bit_idx;
  } ffz_res_t;

endpackage

[rtl/ssba_map_ram.sv]
module ssba_map_ram
  import ssba_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/ssba_ffz.sv]
module ssba_ffz
  import ssba_pkg::*;
(
  input  logic [WORD_W-1:0] word,
  input  logic [LANE_W-1:0] sel_lane,
  output ffz_res_t          res
);

  logic [LANES-1:0] lane_free;
  logic [7:0]       sel_bits;

  // lane level: lowest byte holding a clear bit; bit level: inside the chosen byte
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_free[i] = ~&word[i*8 +: 8];
    end
    sel_bits     = word[sel_lane*8 +: 8];
    res.hit      = |lane_free;
    res.lane_idx = '0;
    res.bit_idx  = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (lane_free[i]) begin
        res.lane_idx = LANE_W'(i);
      end
    end
    for (int i = 7; i >= 0; i--) begin
      if (!sel_bits[i]) begin
        res.bit_idx = 3'(i);
      end
    end
  end

endmodule

[rtl/swap_slot_bitmap_allocator.sv]
// Channel   Ports                   Handshake
// input     in_data (in_t)          taken when start && !busy
// result    out_data (out_t)        out_valid high for one cycle, no back-pressure
//
// Allocate: the accept cycle issues the first map read, then one map read per
// word scanned (1..64 words) and a last step to set the bit; a scan off the top
// reports full instead. A release reads its word, then clears the bit or rejects;
// an allocate with the hint at the top, or an unused opcode, ends in the accept
// cycle. Reset runs a clearing pass over all 64 words with busy high. Results
// cannot be stalled; each shows the cycle after its command ends, when busy is already low.
module swap_slot_bitmap_allocator
  import ssba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_REL   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [HINT_W-1:0] hint_r, hint_nxt;
  logic [ADDR_W-1:0] widx_r, widx_nxt;       // word under scan
  logic              first_r, first_nxt;     // first word: mask bits below hint
  logic [1:0]        op_r, op_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;       // raw word that held a free bit
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [WORD_W-1:0] low_mask, scan_word;
  ffz_res_t          ffz_res;
  logic [SLOT_W-1:0] pick_slot;
  logic              rel_used;

  ssba_map_ram u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // bits below the hint count as taken on the first word only
  assign low_mask  = first_r ? ~({WORD_W{1'b1}} << hint_r[BIT_W-1:0]) : '0;
  assign scan_word = ((state_r == S_PICK) ? word_r : ram_rdata) | low_mask;

  ssba_ffz u_ffz (
    .word     (scan_word),
    .sel_lane (lane_r),
    .res      (ffz_res)
  );

  assign pick_slot = SLOT_W'({widx_r, lane_r, ffz_res.bit_idx});
  assign rel_used  = ram_rdata[slot_r[BIT_W-1:0]];

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    hint_nxt      = hint_r;
    widx_nxt      = widx_r;
    first_nxt     = first_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    word_nxt      = word_r;
    lane_nxt      = lane_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = widx_r;
    ram_wdata     = '0;
    ram_raddr     = widx_r;

    unique case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt   = in_data.opcode;
          slot_nxt = in_data.slot;
          unique case (in_data.opcode) inside
            OP_ALLOC: begin
              if (hint_r >= HINT_W'(SLOT_COUNT)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_FULL, granted_slot: '0};
              end else begin
                ram_raddr = hint_r[BIT_W +: ADDR_W];
                widx_nxt  = hint_r[BIT_W +: ADDR_W];
                first_nxt = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            OP_REL_CHECKED, OP_REL_UNCHECKED: begin
              if ({1'b0, in_data.slot} >= HINT_W'(SLOT_COUNT)) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{status: ST_BAD_RELEASE, granted_slot: '0};
              end else begin
                ram_raddr = in_data.slot[BIT_W +: ADDR_W];
                widx_nxt  = in_data.slot[BIT_W +: ADDR_W];
                state_nxt = S_REL;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ST_OK, granted_slot: '0};
            end
          endcase
        end
      end
      S_SCAN: begin
        if (ffz_res.hit) begin
          word_nxt  = ram_rdata;
          lane_nxt  = ffz_res.lane_idx;
          state_nxt = S_PICK;
        end else if (widx_r == ADDR_W'(WORDS - 1)) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_FULL, granted_slot: '0};
          state_nxt     = S_IDLE;
        end else begin
          widx_nxt  = widx_r + 1'b1;
          ram_raddr = widx_r + 1'b1;
          first_nxt = 1'b0;
        end
      end
      S_PICK: begin
        ram_we        = 1'b1;
        ram_wdata     = word_r | ({{(WORD_W-1){1'b0}}, 1'b1} << {lane_r, ffz_res.bit_idx});
        hint_nxt      = HINT_W'(pick_slot) + 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_OK, granted_slot: pick_slot};
        state_nxt     = S_IDLE;
      end
      S_REL: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (op_r == OP_REL_CHECKED && !rel_used) begin
          out_data_nxt = '{status: ST_BAD_RELEASE, granted_slot: '0};
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata & ~({{(WORD_W-1){1'b0}}, 1'b1} << slot_r[BIT_W-1:0]);
          if (hint_r > {1'b0, slot_r}) begin
            hint_nxt = {1'b0, slot_r};
          end
          out_data_nxt = '{status: ST_OK, granted_slot: '0};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    widx_r     <= widx_nxt;
    first_r    <= first_nxt;
    op_r       <= op_nxt;
    slot_r     <= slot_nxt;
    word_r     <= word_nxt;
    lane_r     <= lane_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
